@@ sv/phr_pkg.sv @@
`timescale 1ns / 1ps

package phr_pkg;

	// register indexes
	localparam logic [0:0] REG_HUE_SHIFT = 1'b0;

	localparam int unsigned HUE_FULL = 360;

	// front end result: numerators and divisors for hue and saturation, the hue sign and the value numerator
	typedef struct packed {
		logic [17:0] hnum;
		logic [8:0]  hden;
		logic        hneg;
		logic [17:0] snum;
		logic [8:0]  sden;
		logic [15:0] vnum;
	} front_t;

	// state of one restoring division in flight
	typedef struct packed {
		logic [17:0] rem;
		logic [17:0] dsh;
		logic [8:0]  quo;
	} div_t;

	function automatic div_t div_init(input logic [17:0] num, input logic [8:0] den);
		div_t d;
		d.rem = num;
		d.dsh = {1'b0, den, 8'd0};
		d.quo = '0;
		return d;
	endfunction

endpackage

@@ sv/pixel_hue_rotator_top.sv @@
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_stall    red_in, green_in, blue_in, alpha_in
// out       out_valid / out_stall  red_out, green_out, blue_out, alpha_out
// config    APB write, pready = 1  hue_shift at byte address 0
//
// One item per clock when out_stall is low.
// Stage 1 finds max/min, stages 2-4 run two restoring dividers at three
// quotient bits each, stage 5 rotates the hue, stages 6-8 rebuild RGB.
// Reset clears the valid bits and sets hue_shift to 0.
// A stall freezes each full stage with no empty stage ahead of it; empty stages still fill behind it.

module pixel_hue_rotator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  alpha_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out
);
	import phr_pkg::*;

	// hue sectors of 60 degrees
	typedef enum logic [2:0] {
		SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
	} sector_t;

	// ---- configuration ----
	logic [8:0] hue_shift_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HUE_SHIFT) ? {23'd0, hue_shift_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_HUE_SHIFT) begin
			hue_shift_q <= pwdata[8:0];
		end
	end

	// ---- flow control: a stage moves when it is empty or the next one moves ----
	logic [8:1] vld;
	logic [8:1] en;

	always_comb begin
		en[8] = !vld[8] || !out_stall;
		for (int i = 7; i >= 1; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld[8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) vld[1] <= in_valid;
			for (int i = 2; i <= 8; i++) begin
				if (en[i]) vld[i] <= vld[i-1];
			end
		end
	end

	// ---- stage 1: extremes, dividends and divisors ----
	front_t fr, fr_s1;
	logic [7:0] a_s1;

	phr_front u_front (
		.red   (red_in),
		.green (green_in),
		.blue  (blue_in),
		.fr    (fr)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fr_s1 <= fr;
			a_s1  <= alpha_in;
		end
	end

	// ---- stages 2-4: hue and saturation dividers, value via reciprocal ----
	div_t hd_in[3], hd_out[3], sd_in[3], sd_out[3];
	div_t hd_s2, hd_s3, hd_s4, sd_s2, sd_s3, sd_s4;
	logic [31:0] vprod;
	logic [6:0] v_s2, v_s3, v_s4;
	logic       n_s2, n_s3, n_s4;
	logic [7:0] a_s2, a_s3, a_s4;

	assign hd_in[0] = div_init(fr_s1.hnum, fr_s1.hden);
	assign sd_in[0] = div_init(fr_s1.snum, fr_s1.sden);
	assign hd_in[1] = hd_s2;
	assign sd_in[1] = sd_s2;
	assign hd_in[2] = hd_s3;
	assign sd_in[2] = sd_s3;

	for (genvar g = 0; g < 3; g++) begin : g_div
		phr_div_step u_hdiv (.din(hd_in[g]), .dout(hd_out[g]));
		phr_div_step u_sdiv (.din(sd_in[g]), .dout(sd_out[g]));
	end

	// floor(x / 510) for x below 2^16
	assign vprod = {16'd0, fr_s1.vnum} * 32'd32897;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			hd_s2 <= hd_out[0];
			sd_s2 <= sd_out[0];
			v_s2  <= vprod[30:24];
			n_s2  <= fr_s1.hneg;
			a_s2  <= a_s1;
		end
		if (en[3]) begin
			hd_s3 <= hd_out[1];
			sd_s3 <= sd_out[1];
			v_s3  <= v_s2;
			n_s3  <= n_s2;
			a_s3  <= a_s2;
		end
		if (en[4]) begin
			hd_s4 <= hd_out[2];
			sd_s4 <= sd_out[2];
			v_s4  <= v_s3;
			n_s4  <= n_s3;
			a_s4  <= a_s3;
		end
	end

	// ---- stage 5: rotate hue, split into sector and offset ----
	logic [8:0] hue;
	logic [9:0] hsum, hrot;
	logic [8:0] h;
	sector_t    k;
	logic [8:0] rem;
	logic [5:0] f;
	sector_t    k_s5;
	logic [5:0] f_s5;
	logic [6:0] v_s5, s_s5;
	logic [7:0] a_s5;

	always_comb begin
		// a negative red-sector hue wraps once; a hue rounding to -0 stays 0
		hue  = (n_s4 && hd_s4.quo != 9'd0) ? 9'(HUE_FULL) - hd_s4.quo : hd_s4.quo;
		hsum = {1'b0, hue} + {1'b0, hue_shift_q};
		if (hsum >= 10'(2 * HUE_FULL)) hrot = hsum - 10'(2 * HUE_FULL);
		else if (hsum >= 10'(HUE_FULL)) hrot = hsum - 10'(HUE_FULL);
		else hrot = hsum;
		h = (hrot == 10'd0) ? 9'd1 : hrot[8:0];
		if (h >= 9'd300) begin
			k = SEC_MR; rem = h - 9'd300;
		end else if (h >= 9'd240) begin
			k = SEC_BM; rem = h - 9'd240;
		end else if (h >= 9'd180) begin
			k = SEC_CB; rem = h - 9'd180;
		end else if (h >= 9'd120) begin
			k = SEC_GC; rem = h - 9'd120;
		end else if (h >= 9'd60) begin
			k = SEC_YG; rem = h - 9'd60;
		end else begin
			k = SEC_RY; rem = h;
		end
		f = k[0] ? 6'(9'd60 - rem) : rem[5:0];
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			k_s5 <= k;
			f_s5 <= f;
			v_s5 <= v_s4;
			s_s5 <= (v_s4 == 7'd0) ? 7'd0 : sd_s4.quo[6:0];
			a_s5 <= a_s4;
		end
	end

	// ---- stage 6: v*s, v*(100-s) and v*6000 ----
	logic [13:0] vs_s6, vn_s6;
	logic [19:0] cm_s6;
	sector_t     k_s6;
	logic [5:0]  f_s6;
	logic [7:0]  a_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			vs_s6 <= {7'd0, v_s5} * {7'd0, s_s5};
			vn_s6 <= {7'd0, v_s5} * (14'd100 - {7'd0, s_s5});
			cm_s6 <= {13'd0, v_s5} * 20'd6000;
			k_s6  <= k_s5;
			f_s6  <= f_s5;
			a_s6  <= a_s5;
		end
	end

	// ---- stage 7: numerators in 1/600000 units, ordered by sector ----
	logic [19:0] mm, xm;
	logic [19:0] ro, go, bo;
	logic [19:0] ro_s7, go_s7, bo_s7;
	logic [7:0]  a_s7;

	always_comb begin
		mm = {vn_s6, 6'd0} - {4'd0, vn_s6, 2'd0};
		xm = {6'd0, vs_s6} * {14'd0, f_s6} + mm;
		unique case (k_s6)
			SEC_RY: begin ro = cm_s6; go = xm;    bo = mm;    end
			SEC_YG: begin ro = xm;    go = cm_s6; bo = mm;    end
			SEC_GC: begin ro = mm;    go = cm_s6; bo = xm;    end
			SEC_CB: begin ro = mm;    go = xm;    bo = cm_s6; end
			SEC_BM: begin ro = xm;    go = mm;    bo = cm_s6; end
			default: begin ro = cm_s6; go = mm;   bo = xm;    end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ro_s7 <= ro;
			go_s7 <= go;
			bo_s7 <= bo;
			a_s7  <= a_s6;
		end
	end

	// ---- stage 8: scale to 8 bits, output register ----
	logic [7:0] rc, gc, bc;
	logic [7:0] r_s8, g_s8, b_s8, a_s8;

	phr_chan u_chan_r (.num(ro_s7), .chan(rc));
	phr_chan u_chan_g (.num(go_s7), .chan(gc));
	phr_chan u_chan_b (.num(bo_s7), .chan(bc));

	always_ff @(posedge clk) begin
		if (en[8]) begin
			r_s8 <= rc;
			g_s8 <= gc;
			b_s8 <= bc;
			a_s8 <= a_s7;
		end
	end

	assign red_out   = r_s8;
	assign green_out = g_s8;
	assign blue_out  = b_s8;
	assign alpha_out = a_s8;

`ifndef SYNTHESIS
	// back-pressure only ever comes from a full pipe behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld == 8'hFF && out_stall))
		else $error("input stalled with room in the pipe");

	// offset within a sector never exceeds 60 degrees
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		vld[5] |-> f_s5 <= 6'd60)
		else $error("sector offset out of range");

	// saturation and value are percents
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld[5] |-> s_s5 <= 7'd100 && v_s5 <= 7'd100)
		else $error("saturation or value out of range");
`endif

endmodule

@@ sv/phr_front.sv @@
`timescale 1ns / 1ps

module phr_front (
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	output phr_pkg::front_t fr
);
	import phr_pkg::*;

	logic [7:0]  mx, mn, c, d;
	logic [10:0] e;
	logic [16:0] n;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		c = mx - mn;
		d = (green >= blue) ? green - blue : blue - green;
		fr.hneg = 1'b0;
		if (red == mx) begin
			e = {3'd0, d};
			fr.hneg = blue > green;
		end else if (green == mx) begin
			e = {3'd0, blue} + {2'd0, c, 1'b0} - {3'd0, red};
		end else begin
			e = {3'd0, red} + {1'b0, c, 2'd0} - {3'd0, green};
		end
		n = {e, 6'd0} - {4'd0, e, 2'd0};
		if (c == 8'd0) begin
			fr.hnum = '0;
			fr.hden = 9'd1;
			fr.hneg = 1'b0;
		end else begin
			fr.hnum = {n, 1'b0} + {10'd0, c};
			fr.hden = {c, 1'b0};
		end
		if (mx == 8'd0) begin
			fr.snum = '0;
			fr.sden = 9'd1;
		end else begin
			fr.snum = {2'd0, c, 8'd0} - {5'd0, c, 5'd0} - {6'd0, c, 4'd0}
				- {7'd0, c, 3'd0} + {10'd0, mx};
			fr.sden = {mx, 1'b0};
		end
		fr.vnum = {mx, 8'd0} - {3'd0, mx, 5'd0} - {4'd0, mx, 4'd0} - {5'd0, mx, 3'd0}
			+ 16'd255;
	end

endmodule

@@ sv/phr_div_step.sv @@
`timescale 1ns / 1ps

module phr_div_step (
	input  phr_pkg::div_t din,
	output phr_pkg::div_t dout
);
	import phr_pkg::*;

	div_t t;

	// three quotient bits per stage
	always_comb begin
		t = din;
		for (int i = 0; i < 3; i++) begin
			if (t.rem >= t.dsh) begin
				t.rem = t.rem - t.dsh;
				t.quo = {t.quo[7:0], 1'b1};
			end else begin
				t.quo = {t.quo[7:0], 1'b0};
			end
			t.dsh = {1'b0, t.dsh[17:1]};
		end
		dout = t;
	end

endmodule

@@ sv/phr_chan.sv @@
`timescale 1ns / 1ps

module phr_chan (
	input  logic [19:0] num,
	output logic [7:0]  chan
);
	// round(num * 255 / 600000) = floor((34*num + 40000) / 80000)
	logic [24:0] y;
	logic [36:0] p;
	logic [8:0]  q;

	always_comb begin
		y = {num, 5'd0} + {4'd0, num, 1'b0} + 25'd40000;
		// divide by 128, then by 625 through a reciprocal
		p = {1'b0, y[24:7]} * 37'd429497;
		q = p[36:28];
		chan = (q > 9'd255) ? 8'd255 : q[7:0];
	end

endmodule

@@ tb/pixel_hue_rotator_top_test.sv @@
`timescale 1ns / 1ps

module pixel_hue_rotator_top_test;
	import phr_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red_out, green_out, blue_out, alpha_out;

	// shadow of the hue shift register as the block should hold it
	logic [8:0] shift_shadow = '0;
	pixel_t     pixels_due[$];
	int         mismatches = 0;
	bit         stall_quiet = 1'b0;

	pixel_hue_rotator_top u_dut (.*);

	always #5 clk = ~clk;

	// round half away from zero of n/d, d > 0
	function automatic int rhaz(input int n, input int d);
		if (n >= 0)
			return (2 * n + d) / (2 * d);
		return -((-2 * n + d) / (2 * d));
	endfunction

	function automatic logic [7:0] to_chan(input longint unsigned num);
		longint unsigned v;
		v = (num * 510 + 600000) / 1200000;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// expected rotated pixel for the current shift
	function automatic pixel_t rotate_pixel(input pixel_t p);
		int r, g, b, mx, mn, c, hue, val, sat, h, k, rm, f;
		longint unsigned cm, xm, mm;
		pixel_t o;
		r = p.r; g = p.g; b = p.b;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		c = mx - mn;
		if (c == 0) hue = 0;
		else if (r == mx) begin
			hue = rhaz((g - b) * 60, c);
			if (hue < 0) hue += 360;
		end else if (g == mx) hue = rhaz((b - r + 2 * c) * 60, c);
		else hue = rhaz((r - g + 4 * c) * 60, c);
		val = rhaz(mx * 100, 255);
		sat = (val == 0 || mx == 0) ? 0 : rhaz(c * 100, mx);
		h = (hue + int'(shift_shadow)) % 360;
		if (h == 0) h = 1;
		k = h / 60;
		rm = h % 60;
		f = (k % 2) ? 60 - rm : rm;
		cm = 6000 * val;
		mm = 60 * val * (100 - sat);
		xm = val * sat * f + mm;
		case (k)
			0: begin o.r = to_chan(cm); o.g = to_chan(xm); o.b = to_chan(mm); end
			1: begin o.r = to_chan(xm); o.g = to_chan(cm); o.b = to_chan(mm); end
			2: begin o.r = to_chan(mm); o.g = to_chan(cm); o.b = to_chan(xm); end
			3: begin o.r = to_chan(mm); o.g = to_chan(xm); o.b = to_chan(cm); end
			4: begin o.r = to_chan(xm); o.g = to_chan(mm); o.b = to_chan(cm); end
			default: begin o.r = to_chan(cm); o.g = to_chan(mm); o.b = to_chan(xm); end
		endcase
		o.a = p.a;
		return o;
	endfunction

	// receiver stall pattern: random duty that changes now and then
	int stall_pct = 30;
	always @(posedge clk) begin
		if (($urandom % 64) == 0)
			stall_pct <= $urandom_range(0, 3) * 25;
		out_stall <= !stall_quiet && ($urandom_range(0, 99) < stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item %h %h %h %h",
						red_out, green_out, blue_out, alpha_out);
			end else begin
				want = pixels_due.pop_front();
				if (want !== {red_out, green_out, blue_out, alpha_out}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want rgba %h %h %h %h got %h %h %h %h",
							want.r, want.g, want.b, want.a,
							red_out, green_out, blue_out, alpha_out);
				end
			end
		end
	end

	int burst_left = 0;

	// one item; gaps come between random bursts
	task automatic send_pixel(input pixel_t p);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		{red_in, green_in, blue_in, alpha_in} <= p;
		pixels_due.push_back(rotate_pixel(p));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// APB write, only with the pipe empty
	task automatic write_shift(input logic [8:0] val);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_HUE_SHIFT, 2'b00};
		pwdata <= {23'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		shift_shadow = val;
		@(posedge clk);
	endtask

	function automatic pixel_t rand_pixel();
		return pixel_t'($urandom);
	endfunction

	// extremes, greys, each max branch, negative red hue, value rounding to zero
	task automatic test_directed;
		pixel_t set[$];
		set = '{32'h00000000, 32'hFFFFFFFF, 32'h010101AA, 32'h80808055,
			32'hFF000001, 32'h00FF0002, 32'h0000FF03, 32'hFF00FF04,
			32'hFFFF0005, 32'h00FFFF06, 32'h01000007, 32'h00010008,
			32'h02000109, 32'hFF80400A, 32'h40FF800B, 32'h8040FF0C,
			32'hFF7F7F0D, 32'h7F00000E, 32'hC8C8C90F, 32'h0102037F,
			32'hFE0001F0};
		foreach (set[i]) send_pixel(set[i]);
		drain();
	endtask

	// sweep of shifts, extremes included
	task automatic test_shifts;
		logic [8:0] shifts[$];
		shifts = '{9'd0, 9'd359, 9'd1, 9'd180, 9'd300, 9'd60};
		foreach (shifts[i]) begin
			write_shift(shifts[i]);
			repeat (20) send_pixel(rand_pixel());
			drain();
		end
	endtask

	task automatic test_random;
		pixel_t p;
		write_shift(9'($urandom_range(0, 359)));
		for (int i = 0; i < 600; i++) begin
			p = rand_pixel();
			// some near-grey pixels to hit ties and small chroma
			if (($urandom % 4) == 0) begin
				p.g = 8'(p.r + $urandom_range(0, 2));
				p.b = 8'(p.r - $urandom_range(0, 2));
			end
			send_pixel(p);
			if (i == 300) begin
				drain();
				write_shift(9'($urandom_range(0, 359)));
			end
		end
		drain();
	endtask

	// no stall, back-to-back items at full rate
	task automatic test_full_rate;
		stall_quiet = 1'b1;
		burst_left = 40;
		repeat (40) send_pixel(rand_pixel());
		drain();
		stall_quiet = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_shifts();
		test_full_rate();
		test_random();
		if (mismatches == 0 && pixels_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
sv/phr_pkg.sv
sv/phr_front.sv
sv/phr_div_step.sv
sv/phr_chan.sv
sv/pixel_hue_rotator_top.sv
tb/pixel_hue_rotator_top_test.sv
